### rtl/core/dabd_pkg.sv
`default_nettype none

package dabd_pkg;

    // Widths of the request and result fields.
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 6;
    localparam int DIGIT_W = 4;

    // Size of the digit buffer; 10 holds every 32-bit value.
    localparam int MAX_DIGITS = 10;
    localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // Division by ten as a multiply by the rounded-up reciprocal 2^35 / 10.
    localparam int                  PROD_W      = 2 * VALUE_W;
    localparam int                  RECIP_SHIFT = 35;
    localparam int                  QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [VALUE_W-1:0]  RECIP_TEN   = 32'hCCCC_CCCD;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIGIT,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;  // able to take a new request
        logic load;   // request taken this cycle
        logic mul;    // form the reciprocal product
        logic digit;  // split off one digit
        logic emit;   // move one digit into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_last;  // this digit step is the final one
        logic out_free;   // output register can take a digit
        logic emit_last;  // the digit being emitted is the least significant
    } status_t;

endpackage

`default_nettype wire

### rtl/core/dabd_value_if.sv
`default_nettype none

interface dabd_value_if;
    logic                          valid;
    logic                          ready;
    logic [dabd_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

### rtl/core/dabd_digit_if.sv
`default_nettype none

interface dabd_digit_if;
    logic                         valid;
    logic                         ready;
    logic [dabd_pkg::CHAR_W-1:0]  digit_char;
    logic                         last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink (input valid, input digit_char, input last, output ready);
endinterface

`default_nettype wire

### rtl/core/decimal_ascii_binary_to_digits.sv
`default_nettype none

// Binary to decimal text converter. Each request on value_chan carries one
// unsigned 32-bit value, and the block answers with its decimal digits as
// ASCII characters on digit_chan, one digit per result, most significant
// first, without leading zeros; a value of zero gives the single character
// '0'. The last flag is set on the least significant digit, so it closes the
// run of each value. After acceptance a value is converted in order: the
// request is taken, each digit is split off by a divide-by-ten step (a
// reciprocal multiply into a product register, then the quotient and
// remainder split), and the digits are then moved one at a time out of the
// digit buffer into the output register, waiting whenever the sink has not
// taken the digit offered before. The block handles one value at a time; it
// takes the next request while the final digit of the previous one still
// waits in the output register. There are no configuration registers.
module decimal_ascii_binary_to_digits (
    input  wire logic clk,
    input  wire logic rst_n,
    dabd_value_if.sink   value_chan,
    dabd_digit_if.source digit_chan
);

    dabd_pkg::cmd_t    cmd;
    dabd_pkg::status_t status;

    // The controller sequences the conversion: take a request, alternate
    // multiply and digit steps until the quotient reaches zero, then emit
    // the buffered digits from the top down.
    dabd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (value_chan.valid),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the working value, the product register, the digit
    // buffer and the output register.
    dabd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_value  (value_chan.value),
        .out_ready (digit_chan.ready),
        .out_valid (digit_chan.valid),
        .out_char  (digit_chan.digit_char),
        .out_last  (digit_chan.last),
        .status    (status)
    );

    assign value_chan.ready = cmd.ready;

endmodule

`default_nettype wire

### rtl/core/dabd_ctrl.sv
`default_nettype none

module dabd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire dabd_pkg::status_t status,
    output dabd_pkg::cmd_t         cmd
);

    dabd_pkg::state_t state_reg;
    dabd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dabd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dabd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dabd_pkg::ST_MUL;
                end
            end
            dabd_pkg::ST_MUL:
            begin
                state_next = dabd_pkg::ST_DIGIT;
            end
            dabd_pkg::ST_DIGIT:
            begin
                state_next = status.conv_last ? dabd_pkg::ST_EMIT : dabd_pkg::ST_MUL;
            end
            dabd_pkg::ST_EMIT:
            begin
                if (status.out_free && status.emit_last)
                begin
                    state_next = dabd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dabd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            dabd_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                cmd.load  = in_valid;
            end
            dabd_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            dabd_pkg::ST_DIGIT:
            begin
                cmd.digit = 1'b1;
            end
            dabd_pkg::ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/dabd_dp.sv
`default_nettype none

module dabd_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dabd_pkg::cmd_t                cmd,
    input  wire logic [dabd_pkg::VALUE_W-1:0]  in_value,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [dabd_pkg::CHAR_W-1:0]        out_char,
    output logic                               out_last,
    output dabd_pkg::status_t                  status
);

    logic [dabd_pkg::VALUE_W-1:0] val_reg;
    logic [dabd_pkg::PROD_W-1:0]  prod_reg;
    logic [dabd_pkg::DIGIT_W-1:0] digits_reg [dabd_pkg::MAX_DIGITS];
    logic [dabd_pkg::IDX_W-1:0]   wr_ptr_reg;
    logic [dabd_pkg::IDX_W-1:0]   rd_ptr_reg;
    logic                         out_valid_reg;
    logic [dabd_pkg::CHAR_W-1:0]  out_char_reg;
    logic                         out_last_reg;

    logic [dabd_pkg::QUOT_W-1:0]  quot;
    logic [dabd_pkg::DIGIT_W-1:0] quot_x10_low;
    logic [dabd_pkg::DIGIT_W-1:0] rem;

    // The quotient comes from the registered product; the remainder is
    // known to be below ten, so only its low four bits need computing.
    assign quot         = prod_reg[dabd_pkg::PROD_W-1:dabd_pkg::RECIP_SHIFT];
    assign quot_x10_low = {quot[0], 3'b000} + {quot[2:0], 1'b0};
    assign rem          = val_reg[dabd_pkg::DIGIT_W-1:0] - quot_x10_low;

    assign status.conv_last = (quot == '0)
        || (wr_ptr_reg == dabd_pkg::IDX_W'(dabd_pkg::MAX_DIGITS - 1));
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.emit_last = (rd_ptr_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg <= in_value;
        end
        else if (cmd.digit)
        begin
            val_reg <= dabd_pkg::VALUE_W'(quot);
        end
        if (cmd.mul)
        begin
            prod_reg <= dabd_pkg::PROD_W'(val_reg) * dabd_pkg::PROD_W'(dabd_pkg::RECIP_TEN);
        end
        if (cmd.digit)
        begin
            digits_reg[wr_ptr_reg] <= rem;
        end
        if (cmd.emit)
        begin
            out_char_reg <= dabd_pkg::ASCII_ZERO
                + dabd_pkg::CHAR_W'(digits_reg[rd_ptr_reg]);
            out_last_reg <= (rd_ptr_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                wr_ptr_reg <= '0;
            end
            else if (cmd.digit && !status.conv_last)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end

            if (cmd.digit && status.conv_last)
            begin
                rd_ptr_reg <= wr_ptr_reg;
            end
            else if (cmd.emit)
            begin
                rd_ptr_reg <= rd_ptr_reg - 1'b1;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_char_reg >= dabd_pkg::ASCII_ZERO
                           && out_char_reg <= dabd_pkg::ASCII_NINE))
        else $error("digit character out of range");

    a_load_clears_wr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (wr_ptr_reg == '0))
        else $error("write pointer not cleared on new request");

    a_rd_from_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.digit && status.conv_last) |=> (rd_ptr_reg == $past(wr_ptr_reg)))
        else $error("read pointer does not start at the top digit");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("digit emitted over a pending result");

endmodule

`default_nettype wire
